// ----- design/rcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcbc_pkg: shared types and constants for the ray convex brush clipper
// Fixed-point formats, item kind codes, multiplier operand selects and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcbc_pkg;

  localparam int COORD_FRAC_BITS = 12;   // fraction bits of coordinates
  localparam int UNIT_FRAC       = 14;   // fraction bits of unit vectors
  localparam int FRAC_Q          = 30;   // fraction bits of the crossing ratio
  localparam int MAX_FACES       = 64;
  localparam int REACH_W         = 17;
  localparam logic [REACH_W-1:0] REACH_RESET = 17'd16384;
  localparam int DIV_STEPS       = FRAC_Q;
  localparam int MAG_W           = 51;   // magnitude of a plane distance

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_FACE  = 2'd1,
    KIND_LAST  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MOP_REACH,
    MOP_DOT_NEAR,
    MOP_DOT_FAR,
    MOP_UPD,
    MOP_DIST
  } mop_t;

  typedef struct packed {
    logic       load;
    mop_t       op;
    logic [1:0] axis;
    logic       acc_init;
    logic       acc_clr;
    logic       acc_add;
    logic       reach_wr;
    logic       d1_wr;
    logic       div_init;
    logic       div_step;
    logic       upd_wr;
    logic       entry_upd;
    logic       out_load;
    logic       out_hit;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  finished;
    logic  fid_ok;
    logic  entry_seen;
    logic  d1_ge0;
    logic  d1_le0;
    logic  d2_ge0;
    logic  d2_le0;
    logic  out_busy;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/rcbc_if.sv -----
// ----------------------------------------------------------------------------
// rcbc_if: item and result channels of the ray convex brush clipper
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rcbc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] plane_offset;
  logic [5:0]         face_id;

  modport source (output valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  normal_x, normal_y, normal_z, plane_offset, face_id, input ready);
  modport sink (input valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                normal_x, normal_y, normal_z, plane_offset, face_id, output ready);
endinterface

interface rcbc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [5:0]         hit_face;
  logic signed [31:0] hit_distance;

  modport source (output valid, hit, hit_face, hit_distance, input ready);
  modport sink (input valid, hit, hit_face, hit_distance, output ready);
endinterface

// ----- design/rcbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcbc_ctrl: sequencer of the ray convex brush clipper
// Steps the shared multiplier, divider and update writes for each item.
// ----------------------------------------------------------------------------
module rcbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  output logic             in_rdy,
  input  rcbc_pkg::dp_sts_t sts,
  output rcbc_pkg::dp_cmd_t cmd
);
  import rcbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_REACH, ST_DOT1, ST_DOT2, ST_CLASS,
    ST_DIV, ST_UPD, ST_LAST, ST_DIST, ST_RESULT
  } state_t;

  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic       hit_r, hit_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dcnt_nxt  = dcnt_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    cmd.op    = MOP_REACH;
    cmd.axis  = (cnt_r == 2'd3) ? 2'd0 : cnt_r;
    in_rdy    = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        cnt_nxt = 2'd0;
        if (sts.kind == KIND_START) state_nxt = ST_REACH;
        else if (sts.kind == KIND_NONE || sts.finished) state_nxt = ST_IDLE;
        else if (sts.fid_ok) state_nxt = ST_DOT1;
        else state_nxt = ST_LAST;
      end
      ST_REACH: begin
        cmd.op       = MOP_REACH;
        cmd.reach_wr = (cnt_r != 2'd0);
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = ST_IDLE;
      end
      ST_DOT1, ST_DOT2: begin
        cmd.op       = (state_r == ST_DOT1) ? MOP_DOT_NEAR : MOP_DOT_FAR;
        cmd.acc_init = (cnt_r == 2'd0);
        cmd.acc_add  = (cnt_r != 2'd0);
        cmd.d1_wr    = (state_r == ST_DOT2) && (cnt_r == 2'd0);
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = (state_r == ST_DOT1) ? ST_DOT2 : ST_CLASS;
      end
      ST_CLASS: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        cnt_nxt      = 2'd0;
        if (sts.d1_ge0 && sts.d2_ge0) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else if (sts.d1_le0 && sts.d2_le0) begin
          state_nxt = ST_LAST;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 5'd1;
        if (dcnt_r == DIV_LAST) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.op        = MOP_UPD;
        cmd.upd_wr    = (cnt_r != 2'd0);
        cmd.entry_upd = (cnt_r == 2'd3);
        cnt_nxt       = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        cnt_nxt = 2'd0;
        if (sts.kind != KIND_LAST) begin
          state_nxt = ST_IDLE;
        end else if (sts.entry_seen) begin
          state_nxt = ST_DIST;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end
      end
      ST_DIST: begin
        cmd.op      = MOP_DIST;
        cmd.acc_clr = (cnt_r == 2'd0);
        cmd.acc_add = (cnt_r != 2'd0);
        cnt_nxt     = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.out_hit = hit_r;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dcnt_r  <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dcnt_r  <= dcnt_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

// ----- design/rcbc_dp.sv -----
// ----------------------------------------------------------------------------
// rcbc_dp: datapath of the ray convex brush clipper
// Ray and segment registers, one shared multiplier with accumulator, a
// restoring divider for the crossing ratio and the result register.
// ----------------------------------------------------------------------------
module rcbc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rcbc_pkg::REACH_W-1:0]    far_reach,
  input  rcbc_pkg::dp_cmd_t               cmd,
  output rcbc_pkg::dp_sts_t               sts,
  rcbc_in_if.sink                         in_ch,
  rcbc_out_if.source                      out_ch
);
  import rcbc_pkg::*;

  logic signed [31:0] org_r  [3];
  logic signed [15:0] dir_r  [3];
  logic signed [31:0] near_r [3];
  logic signed [31:0] far_r  [3];
  logic signed [15:0] nrm_r  [3];
  logic signed [31:0] off_r;
  logic [1:0]         kind_r;
  logic [5:0]         fid_r;
  logic [5:0]         entry_face_r;
  logic               entry_seen_r;
  logic               finished_r;

  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [63:0] prod_r;
  logic [1:0]         axis_d_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] d1_r;

  logic [MAG_W+1:0]   rem_r;
  logic [MAG_W:0]     den_r;
  logic [FRAC_Q-1:0]  q_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [5:0]         out_face_r;
  logic signed [31:0] out_dist_r;

  logic signed [63:0] reach_s, reach_t, far_v, np_v, dist_v;
  logic [63:0]        a1_full, a2_full;
  logic [MAG_W+1:0]   rem_sh;
  logic               d1_pos;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      MOP_REACH: begin
        mul_a = 34'(dir_r[cmd.axis]);
        mul_b = 31'(far_reach);
      end
      MOP_DOT_NEAR: begin
        mul_a = 34'(near_r[cmd.axis]);
        mul_b = 31'(nrm_r[cmd.axis]);
      end
      MOP_DOT_FAR: begin
        mul_a = 34'(far_r[cmd.axis]);
        mul_b = 31'(nrm_r[cmd.axis]);
      end
      MOP_UPD: begin
        mul_a = 34'(far_r[cmd.axis]) - 34'(near_r[cmd.axis]);
        mul_b = 31'(q_r);
      end
      MOP_DIST: begin
        mul_a = 34'(near_r[cmd.axis]) - 34'(org_r[cmd.axis]);
        mul_b = 31'(dir_r[cmd.axis]);
      end
      default: ;
    endcase
  end

  always_comb begin
    reach_s = prod_r <<< COORD_FRAC_BITS;
    reach_t = (reach_s + (64'sd1 <<< (UNIT_FRAC - 1))) >>> UNIT_FRAC;
    far_v   = 64'(org_r[axis_d_r]) + reach_t;
    np_v    = 64'(near_r[axis_d_r]) + ((prod_r + (64'sd1 <<< (FRAC_Q - 1))) >>> FRAC_Q);
    dist_v  = (acc_r + (64'sd1 <<< (UNIT_FRAC - 1))) >>> UNIT_FRAC;
    a1_full = d1_r[63] ? 64'(-d1_r) : 64'(d1_r);
    a2_full = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    rem_sh  = {rem_r[MAG_W:0], 1'b0};
    d1_pos  = !d1_r[63] && (d1_r != 64'sd0);
  end

  always_ff @(posedge clk) begin
    prod_r   <= 64'(mul_a * mul_b);
    axis_d_r <= cmd.axis;

    if (cmd.load) begin
      kind_r   <= in_ch.kind;
      fid_r    <= in_ch.face_id;
      off_r    <= in_ch.plane_offset;
      nrm_r[0] <= in_ch.normal_x;
      nrm_r[1] <= in_ch.normal_y;
      nrm_r[2] <= in_ch.normal_z;
      if (in_ch.kind == KIND_START) begin
        org_r[0]  <= in_ch.origin_x;
        org_r[1]  <= in_ch.origin_y;
        org_r[2]  <= in_ch.origin_z;
        near_r[0] <= in_ch.origin_x;
        near_r[1] <= in_ch.origin_y;
        near_r[2] <= in_ch.origin_z;
        dir_r[0]  <= in_ch.dir_x;
        dir_r[1]  <= in_ch.dir_y;
        dir_r[2]  <= in_ch.dir_z;
      end
    end

    if (cmd.reach_wr) far_r[axis_d_r] <= sat32(far_v);

    if (cmd.upd_wr) begin
      if (d1_pos) near_r[axis_d_r] <= np_v[31:0];
      else far_r[axis_d_r] <= np_v[31:0];
    end

    if (cmd.acc_init) acc_r <= -(64'(off_r) <<< UNIT_FRAC);
    else if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + prod_r;

    if (cmd.d1_wr) d1_r <= acc_r;

    if (cmd.div_init) begin
      rem_r <= (MAG_W + 2)'(a1_full[MAG_W-1:0]);
      den_r <= (MAG_W + 1)'(a1_full[MAG_W-1:0]) + (MAG_W + 1)'(a2_full[MAG_W-1:0]);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= (MAG_W + 2)'(den_r)) begin
        rem_r <= rem_sh - (MAG_W + 2)'(den_r);
        q_r   <= {q_r[FRAC_Q-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[FRAC_Q-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      out_hit_r  <= cmd.out_hit;
      out_face_r <= cmd.out_hit ? entry_face_r : 6'd0;
      out_dist_r <= cmd.out_hit ? sat32(dist_v) : 32'sd0;
    end
  end

  // Ray control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r   <= 1'b1;
      entry_seen_r <= 1'b0;
      entry_face_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load && in_ch.kind == KIND_START) begin
        finished_r   <= 1'b0;
        entry_seen_r <= 1'b0;
        entry_face_r <= '0;
      end
      if (cmd.entry_upd && d1_pos) begin
        entry_seen_r <= 1'b1;
        entry_face_r <= fid_r;
      end
      if (cmd.out_load) begin
        finished_r  <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.kind       = kind_t'(kind_r);
  assign sts.finished   = finished_r;
  assign sts.fid_ok     = (7'(fid_r) < 7'(MAX_FACES));
  assign sts.entry_seen = entry_seen_r;
  assign sts.d1_ge0     = !d1_r[63];
  assign sts.d1_le0     = d1_r[63] || (d1_r == 64'sd0);
  assign sts.d2_ge0     = !acc_r[63];
  assign sts.d2_le0     = acc_r[63] || (acc_r == 64'sd0);
  assign sts.out_busy   = out_valid_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_face     = out_face_r;
  assign out_ch.hit_distance = out_dist_r;

endmodule

// ----- design/ray_convex_brush_clip.sv -----
// ----------------------------------------------------------------------------
// ray_convex_brush_clip: clips a ray against the faces of one convex brush
// Sequence: a ray start computes the far point; a face misses, is skipped
// or clips, and a clipping face runs the 30-step divider and the segment
// update; the last face may add distance work and the result hand-off.
// Throughput: one item at a time; a result waits in an output register.
// Reset: synchronous, active low; no ray is active and far_reach is 16384.
// ----------------------------------------------------------------------------
module ray_convex_brush_clip (
  input  logic        clk,
  input  logic        rst_n,
  rcbc_in_if.sink     in_ch,
  rcbc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rcbc_pkg::*;

  // The controller walks each item through the shared multiplier and the
  // divider in the datapath; the two talk only through the command and
  // status bundles below.
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_rdy;
  logic    in_fire;

  // One register, far_reach, answers at addresses 0 to 3; address bit 2 selects beyond the list.
  logic [REACH_W-1:0] far_reach_r;
  logic               cfg_we;

  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(far_reach_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_reach_r <= REACH_RESET;
    end else if (cfg_we) begin
      far_reach_r <= cfg_pwdata[REACH_W-1:0];
    end
  end

  // A beat is taken only while the controller is idle.
  assign in_ch.ready = in_rdy;
  assign in_fire     = in_ch.valid && in_rdy;

  rcbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_rdy  (in_rdy),
    .sts     (sts),
    .cmd     (cmd)
  );

  rcbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .far_reach (far_reach_r),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // After a beat is accepted the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted on consecutive cycles");

  // A result is loaded only into an empty output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result overwrote a pending result");

  // Every reported result ends the ray.
  a_result_ends_ray: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> sts.finished)
    else $error("ray still active after its result");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ray convex brush clipper
// Sends ray start and face plane beats, and keeps its own model of the
// clipping arithmetic to predict every result. It sweeps far_reach over
// several settings and puts random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rcbc_pkg::*;

  // One input beat as the bench builds it.
  typedef struct {
    kind_t              kind;
    logic signed [31:0] org [3];
    logic signed [15:0] dir [3];
    logic signed [15:0] nrm [3];
    logic signed [31:0] offset;
    logic [5:0]         fid;
  } beat_t;

  // One clip result: hit flag, entering face and distance along the ray.
  typedef struct {
    logic               hit;
    logic [5:0]         face;
    logic signed [31:0] distance;
  } clip_res_t;

  // A directed row. Where typed is set, the result is written in by hand.
  typedef struct {
    beat_t     b;
    bit        typed;
    clip_res_t res;
  } stim_row_t;

  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_WAIT  = 100;   // longer than a clipping last face

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rcbc_in_if  in_ch ();
  rcbc_out_if out_ch ();

  ray_convex_brush_clip i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // The clock runs at 8 ns.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Model state of the clipper, updated as each input beat is accepted.
  longint        ray_org  [3];
  longint        ray_dir  [3];
  longint        near_pt  [3];
  longint        far_pt   [3];
  logic [5:0]    entry_fid;
  bit            entry_hit;
  bit            ray_done;
  logic [16:0]   reach_reg;

  clip_res_t pending_res [$];
  int        fail_cnt;
  int        beats_sent;
  int        results_seen;
  int        hits_seen;
  int        idle_cycles;
  bit        no_idle;   // when set, both sides run without gaps

  // Floor of (v + half) / 2^s: rounding half up toward plus infinity.
  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return longint'(32'sh7fffffff);
    if (v < longint'(32'sh80000000)) return longint'(32'sh80000000);
    return v;
  endfunction

  // Restoring division giving |d1| / (|d1| + |d2|) as unsigned Q0.30.
  function automatic longint unsigned cross_ratio(longint unsigned num,
                                                  longint unsigned den);
    longint unsigned r;
    longint unsigned q;
    r = num;
    q = 0;
    for (int i = 0; i < FRAC_Q; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Applies one beat to the model; returns 1 when the beat gives a result.
  function automatic bit clip_beat(beat_t b, output clip_res_t res);
    longint d1;
    longint d2;
    longint a1;
    longint a2;
    longint unsigned q;
    longint np [3];
    longint s;
    res = '{hit: 1'b0, face: '0, distance: '0};
    if (b.kind == KIND_START) begin
      for (int i = 0; i < 3; i++) begin
        ray_org[i] = longint'(b.org[i]);
        ray_dir[i] = longint'(b.dir[i]);
        near_pt[i] = ray_org[i];
        far_pt[i]  = clamp32(ray_org[i] + round_up_shift(
                       ray_dir[i] * longint'(reach_reg) * (longint'(1) << COORD_FRAC_BITS),
                       UNIT_FRAC));
      end
      entry_fid = '0;
      entry_hit = 1'b0;
      ray_done  = 1'b0;
      return 1'b0;
    end
    if (b.kind == KIND_NONE || ray_done) return 1'b0;
    // Face ids are 6 bits wide, so every face lies below the face limit.
    d1 = -longint'(b.offset) * (longint'(1) << UNIT_FRAC);
    d2 = d1;
    for (int i = 0; i < 3; i++) begin
      d1 += near_pt[i] * longint'(b.nrm[i]);
      d2 += far_pt[i] * longint'(b.nrm[i]);
    end
    if (d1 >= 0 && d2 >= 0) begin
      ray_done = 1'b1;
      return 1'b1;
    end
    if (!(d1 <= 0 && d2 <= 0)) begin
      a1 = (d1 < 0) ? -d1 : d1;
      a2 = (d2 < 0) ? -d2 : d2;
      q = cross_ratio(a1, a1 + a2);
      for (int i = 0; i < 3; i++)
        np[i] = near_pt[i] + round_up_shift((far_pt[i] - near_pt[i]) * longint'(q), FRAC_Q);
      for (int i = 0; i < 3; i++) begin
        if (d1 > 0) near_pt[i] = np[i];
        else far_pt[i] = np[i];
      end
      if (d1 > 0) begin
        entry_fid = b.fid;
        entry_hit = 1'b1;
      end
    end
    if (b.kind == KIND_LAST) begin
      ray_done = 1'b1;
      if (entry_hit) begin
        s = 0;
        for (int i = 0; i < 3; i++) s += (near_pt[i] - ray_org[i]) * ray_dir[i];
        res.hit      = 1'b1;
        res.face     = entry_fid;
        res.distance = 32'(clamp32(round_up_shift(s, UNIT_FRAC)));
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Drives one beat and waits for it to be taken. Valid is only lowered
  // when a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(beat_t b, bit typed, clip_res_t typed_res);
    int        gap;
    clip_res_t res;
    bit        has_res;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= b.kind;
    in_ch.origin_x     <= b.org[0];
    in_ch.origin_y     <= b.org[1];
    in_ch.origin_z     <= b.org[2];
    in_ch.dir_x        <= b.dir[0];
    in_ch.dir_y        <= b.dir[1];
    in_ch.dir_z        <= b.dir[2];
    in_ch.normal_x     <= b.nrm[0];
    in_ch.normal_y     <= b.nrm[1];
    in_ch.normal_z     <= b.nrm[2];
    in_ch.plane_offset <= b.offset;
    in_ch.face_id      <= b.fid;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    has_res = clip_beat(b, res);
    if (has_res) pending_res.push_back(typed ? typed_res : res);
  endtask

  // Waits for every expected result, lets the block settle, then writes
  // far_reach through a setup phase and an access phase.
  task automatic set_reach(logic [16:0] value);
    in_ch.valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'd0;
    cfg_pwdata  <= {15'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reach_reg = value;
  endtask

  function automatic beat_t mk_beat(kind_t k, int ox, int oy, int oz,
                                    int dx, int dy, int dz, int nx, int ny, int nz,
                                    int off, int fid);
    beat_t b;
    b.kind   = k;
    b.org    = '{ox, oy, oz};
    b.dir    = '{16'(dx), 16'(dy), 16'(dz)};
    b.nrm    = '{16'(nx), 16'(ny), 16'(nz)};
    b.offset = off;
    b.fid    = 6'(fid);
    return b;
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.kind = kind_t'($urandom_range(0, 3));
    for (int i = 0; i < 3; i++) begin
      b.org[i] = $urandom;
      b.dir[i] = 16'($urandom);
      b.nrm[i] = 16'($urandom);
    end
    b.offset = $urandom;
    b.fid    = 6'($urandom);
    return b;
  endfunction

  // One well-formed ray against an axis-aligned box, with an occasional
  // slanted face, in random face order, sometimes one face short. Unused fields carry random bits.
  task automatic box_ray();
    beat_t     b;
    beat_t     faces [$];
    clip_res_t none;
    int        lo;
    int        span;
    none = '{hit: 1'b0, face: '0, distance: '0};
    b = noise_beat();
    b.kind = KIND_START;
    for (int i = 0; i < 3; i++) begin
      b.org[i] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      b.dir[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    send_beat(b, 1'b0, none);
    for (int a = 0; a < 3; a++) begin
      lo   = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      span = $urandom_range(1, 1 << 22);
      b = noise_beat();
      b.kind = KIND_FACE;
      b.nrm = '{16'd0, 16'd0, 16'd0};
      b.nrm[a] = -16'sd16384;
      b.offset = -lo;
      faces.push_back(b);
      b.nrm[a] = 16'sd16384;
      b.offset = lo + span;
      b.fid = 6'($urandom);
      faces.push_back(b);
    end
    if ($urandom_range(0, 3) == 0) begin
      b = noise_beat();
      b.kind = KIND_FACE;
      for (int i = 0; i < 3; i++) b.nrm[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
      b.offset = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      faces.push_back(b);
    end
    faces.shuffle();
    if ($urandom_range(0, 4) == 0) void'(faces.pop_back());
    faces[faces.size() - 1].kind = KIND_LAST;
    foreach (faces[i]) send_beat(faces[i], 1'b0, none);
  endtask

  task automatic random_phase(int n_beats);
    clip_res_t none;
    int        stop_at;
    none = '{hit: 1'b0, face: '0, distance: '0};
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ((beats_sent / 150) % 3 == 2) no_idle = 1'b1;
      else no_idle = 1'b0;
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) send_beat(noise_beat(), 1'b0, none);
      end else begin
        box_ray();
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: a fresh stall for each beat, ready kept high without one.
  initial begin
    int        stall;
    clip_res_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (pending_res.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (out_ch.hit) hits_seen++;
        if (out_ch.hit !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, out_ch.hit);
          fail_cnt++;
        end
        if (out_ch.hit_face !== want.face) begin
          $error("hit_face expected %0d got %0d", want.face, out_ch.hit_face);
          fail_cnt++;
        end
        if (out_ch.hit_distance !== want.distance) begin
          $error("hit_distance expected %0d got %0d", want.distance, out_ch.hit_distance);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: any beat on either channel or a register write restarts it.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t stim_rows [$];

  initial begin
    clip_res_t miss;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_NONE;
    in_ch.origin_x = '0;
    in_ch.origin_y = '0;
    in_ch.origin_z = '0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    in_ch.plane_offset = '0;
    in_ch.face_id = '0;
    fail_cnt = 0;
    beats_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      ray_dir[i] = 0;
      near_pt[i] = 0;
      far_pt[i]  = 0;
    end
    entry_fid = '0;
    entry_hit = 1'b0;
    ray_done  = 1'b1;
    reach_reg = REACH_RESET;
    miss = '{hit: 1'b0, face: '0, distance: '0};

    // Directed rows, run at the reset far_reach. The box spans 10 to 20
    // map units in x and -10 to 10 in y; a miss is typed in where it is obvious.
    // Faces with no ray active, and an unused kind, are all ignored.
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 1), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 2), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_NONE, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 3), 0, miss});
    // A ray along +x enters at the low x face and leaves at the high one;
    // the y faces are behind both ends and are skipped.
    stim_rows.push_back('{mk_beat(KIND_START, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, -16384, 0, 0, -40960, 5), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 81920, 6), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, 0, -16384, 0, 40960, 7), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 40960, 8), 0, miss});
    // Both ends in front of a face: an early miss, and the faces after it
    // are ignored up to and including the last one.
    stim_rows.push_back('{mk_beat(KIND_START, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, 16384, 0, 0, -40960, 9), 1, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0, -16384, 0, 0, -40960, 10), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 11), 0, miss});
    // A last face with no entering face reports a miss.
    stim_rows.push_back('{mk_beat(KIND_START, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, -16384, 0, 0, 40960, 12), 1, miss});
    // A start during a ray drops the old one. Extreme origins, directions
    // and normals drive the far point into saturation.
    stim_rows.push_back('{mk_beat(KIND_START, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_START, 2147483647, 32'sh80000000, 0,
                                  32767, -32768, 0, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0,
                                  -32768, 32767, -32768, 32'sh80000000, 63), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_START, 32'sh80000000, 0, 2147483647,
                                  -32768, 32767, 32767, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_FACE, 0, 0, 0, 0, 0, 0,
                                  32767, -32768, 32767, 2147483647, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 0, -16384, 0, 0), 0, miss});
    // Entering on the last face itself, with the highest face id.
    stim_rows.push_back('{mk_beat(KIND_START, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0), 0, miss});
    stim_rows.push_back('{mk_beat(KIND_LAST, 0, 0, 0, 0, 0, 0, 0, 0, -16384, -40960, 63), 0, miss});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_beat(stim_rows[i].b, stim_rows[i].typed, stim_rows[i].res);

    // Random phases over the far_reach range, ending back at its reset value.
    set_reach(17'd65536);
    random_phase(400);
    set_reach(17'd1);
    random_phase(400);
    set_reach(17'($urandom_range(2, 65535)));
    random_phase(400);
    set_reach(REACH_RESET);
    random_phase(400);

    in_ch.valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("Sent %0d beats over four far_reach settings; checked %0d results, %0d hits.",
             beats_sent, results_seen, hits_seen);
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rcbc_pkg.sv
design/rcbc_if.sv
design/rcbc_ctrl.sv
design/rcbc_dp.sv
design/ray_convex_brush_clip.sv
bench/tb.sv
